// ----- hdl/itoa_pkg.sv -----
// Shared types and constants for the integer-to-ASCII formatter.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  // Conversion kinds carried in req_type
  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_HEX  = 3'd2;
  localparam logic [2:0] KIND_CHAR = 3'd3;
  localparam logic [2:0] KIND_PCT  = 3'd4;

  localparam int TYPE_W     = 3;
  localparam int WORD_W     = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int DIGITS_W   = NUM_DIGITS * DIGIT_W;
  localparam int POS_W      = $clog2(NUM_DIGITS);

  // Binary bits consumed per conversion step and the resulting step count
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = WORD_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS);

  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PERCENT = 8'h25;

  // Digit glyphs; byte 0 of the packed string is '0'
  localparam logic [15:0][CHAR_W-1:0] DIGIT_GLYPHS = "fedcba9876543210";

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic convert;
    logic scan;
    logic emit_sign;
    logic emit_digit;
    logic emit_byte;
  } itoa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic neg;
    logic pos_zero;
    logic out_free;
  } itoa_stat_t;

endpackage

`default_nettype wire

// ----- hdl/itoa_req_if.sv -----
// Request channel: conversion kind and argument word, valid/ready handshake.
// Depends on itoa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface itoa_req_if;
  logic                            valid;
  logic                            ready;
  logic [itoa_pkg::TYPE_W-1:0]     req_type;
  logic [itoa_pkg::WORD_W-1:0]     arg_word;

  modport source (output valid, output req_type, output arg_word, input ready);
  modport sink   (input valid, input req_type, input arg_word, output ready);
endinterface

`default_nettype wire

// ----- hdl/itoa_char_if.sv -----
// Character channel: one ASCII code per transfer plus an end-of-text mark.
// Depends on itoa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface itoa_char_if;
  logic                            valid;
  logic                            ready;
  logic [itoa_pkg::CHAR_W-1:0]     char_code;
  logic                            last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/itoa_ctrl.sv -----
// Formatter controller: sequences load, conversion, digit scan and emission.
// Depends on itoa_pkg for kind codes and command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module itoa_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  input  wire logic [itoa_pkg::TYPE_W-1:0] req_type,
  output logic                             req_ready,
  input  wire itoa_pkg::itoa_stat_t        stat,
  output itoa_pkg::itoa_cmd_t              cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONVERT,
    S_SCAN,
    S_SIGN,
    S_DIGITS,
    S_BYTE
  } state_t;

  localparam logic [itoa_pkg::STEP_W-1:0] LAST_STEP =
    itoa_pkg::STEP_W'(itoa_pkg::CONV_STEPS - 1);

  state_t                      state, state_next;
  logic [itoa_pkg::STEP_W-1:0] step, step_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_type) inside
            itoa_pkg::KIND_SDEC, itoa_pkg::KIND_UDEC: begin
              cmd.load   = 1'b1;
              step_next  = '0;
              state_next = S_CONVERT;
            end
            itoa_pkg::KIND_HEX: begin
              cmd.load   = 1'b1;
              state_next = S_SCAN;
            end
            itoa_pkg::KIND_CHAR, itoa_pkg::KIND_PCT: begin
              cmd.load   = 1'b1;
              state_next = S_BYTE;
            end
            default: begin
              // unused kind: drop the request
            end
          endcase
        end
      end
      S_CONVERT: begin
        cmd.convert = 1'b1;
        step_next   = step + 1'b1;
        if (step == LAST_STEP) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = stat.neg ? S_SIGN : S_DIGITS;
      end
      S_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          if (stat.pos_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      S_BYTE: begin
        if (stat.out_free) begin
          cmd.emit_byte = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/itoa_dp.sv -----
// Formatter datapath: magnitude, shift-add-3 BCD conversion, digit register,
// leading-digit scan and the registered character output.
// Depends on itoa_pkg for widths, glyphs and command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module itoa_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire itoa_pkg::itoa_cmd_t         cmd,
  output itoa_pkg::itoa_stat_t             stat,
  input  wire logic [itoa_pkg::TYPE_W-1:0] req_type,
  input  wire logic [itoa_pkg::WORD_W-1:0] arg_word,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [itoa_pkg::CHAR_W-1:0]      char_code,
  output logic                             last
);

  logic                          neg;
  logic [itoa_pkg::WORD_W-1:0]   bin;
  logic [itoa_pkg::DIGITS_W-1:0] digits;
  logic [itoa_pkg::POS_W-1:0]    pos;
  logic [itoa_pkg::CHAR_W-1:0]   byte_val;

  logic                          load_neg;
  logic [itoa_pkg::WORD_W-1:0]   bin_conv;
  logic [itoa_pkg::DIGITS_W-1:0] digits_conv;
  logic [itoa_pkg::POS_W-1:0]    msd_pos;
  logic                          emit_any;

  assign load_neg = (req_type == itoa_pkg::KIND_SDEC) && arg_word[itoa_pkg::WORD_W-1];
  assign emit_any = cmd.emit_sign | cmd.emit_digit | cmd.emit_byte;

  assign stat.neg      = neg;
  assign stat.pos_zero = (pos == '0);
  assign stat.out_free = !out_valid || out_ready;

  // Four shift-add-3 steps per cycle
  always_comb begin
    digits_conv = digits;
    bin_conv    = bin;
    for (int s = 0; s < itoa_pkg::BITS_PER_STEP; s++) begin
      for (int d = 0; d < itoa_pkg::NUM_DIGITS; d++) begin
        if (digits_conv[d*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] >= 4'd5) begin
          digits_conv[d*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] =
            digits_conv[d*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] + 4'd3;
        end
      end
      digits_conv = {digits_conv[itoa_pkg::DIGITS_W-2:0], bin_conv[itoa_pkg::WORD_W-1]};
      bin_conv    = {bin_conv[itoa_pkg::WORD_W-2:0], 1'b0};
    end
  end

  // Highest nonzero digit; zero keeps a single digit
  always_comb begin
    msd_pos = '0;
    for (int d = 0; d < itoa_pkg::NUM_DIGITS; d++) begin
      if (digits[d*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] != '0) begin
        msd_pos = itoa_pkg::POS_W'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= load_neg;
      bin      <= load_neg ? (~arg_word + 1'b1) : arg_word;
      digits   <= (req_type == itoa_pkg::KIND_HEX) ? itoa_pkg::DIGITS_W'(arg_word) : '0;
      byte_val <= (req_type == itoa_pkg::KIND_CHAR) ? arg_word[itoa_pkg::CHAR_W-1:0]
                                                    : itoa_pkg::CHAR_PERCENT;
    end else if (cmd.convert) begin
      bin    <= bin_conv;
      digits <= digits_conv;
    end
    if (cmd.scan) begin
      pos <= msd_pos;
    end else if (cmd.emit_digit) begin
      pos <= pos - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_code <= itoa_pkg::CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= itoa_pkg::DIGIT_GLYPHS[digits[pos*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W]];
      last      <= (pos == '0);
    end else if (cmd.emit_byte) begin
      char_code <= byte_val;
      last      <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/integer_to_ascii_formatter.sv -----
// Top level of the integer-to-ASCII formatter: controller plus datapath.
// Depends on itoa_pkg, itoa_req_if, itoa_char_if, itoa_ctrl and itoa_dp.
//
//   Channel | Dir | Payload                      | Per transfer
//   --------+-----+------------------------------+---------------------------
//   req     | in  | req_type[2:0], arg_word[31:0] | one conversion request
//   text    | out | char_code[7:0], last         | one character, last marks end
//
// Steps per request (len = characters):
//   signed/unsigned decimal: load, conversion at four bits per step, one digit
//   scan, then len characters, one per cycle while the sink is ready; hex: load,
//   scan, then len characters; character and percent: load, then the one byte;
//   unused kind: dropped, nothing emitted. Reset (rst, synchronous) returns the
// controller to idle and empties the output. A stalled sink holds the output
// register and freezes emission; the next request is taken while the final character still waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter (
  input  wire logic  clk,
  input  wire logic  rst,
  itoa_req_if.sink   req,
  itoa_char_if.source text
);

  itoa_pkg::itoa_cmd_t  cmd;
  itoa_pkg::itoa_stat_t stat;

  // Sequence the work: load, convert, scan, then emit
  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the argument, convert to digits and drive the output register
  itoa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_type  (req.req_type),
    .arg_word  (req.arg_word),
    .out_ready (text.ready),
    .out_valid (text.valid),
    .char_code (text.char_code),
    .last      (text.last)
  );

  // An accepted request of a known kind occupies the block for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.req_type <= itoa_pkg::KIND_PCT)) |=> !req.ready)
    else $error("request accepted but block still reports ready");

  // Never load a character while the output register is occupied and stalled
  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit || cmd.emit_byte) |-> stat.out_free)
    else $error("character emitted over a stalled output");

  // At most one emission command per cycle
  a_single_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_sign, cmd.emit_digit, cmd.emit_byte}))
    else $error("more than one emission command");

  // While a non-final character is on the output, the text is still in progress
  a_midtext_busy: assert property (@(posedge clk) disable iff (rst)
    (text.valid && !text.last) |-> !req.ready)
    else $error("block idle with text unfinished");

endmodule

`default_nettype wire

// ----- tb/sv/tb_integer_to_ascii_formatter.sv -----
`timescale 1ns / 1ps
// Self-checking bench for integer_to_ascii_formatter: a directed table of requests,
// then random requests under several idle/stall mixes, each character checked in order.
// Depends on itoa_pkg, itoa_req_if, itoa_char_if and the formatter RTL.

module tb_integer_to_ascii_formatter;

  // Kinds the block drops without writing anything
  localparam logic [itoa_pkg::TYPE_W-1:0] KIND_UNUSED_LO  = 3'd5;
  localparam logic [itoa_pkg::TYPE_W-1:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [itoa_pkg::TYPE_W-1:0] KIND_UNUSED_HI  = 3'd7;

  localparam int TEXT_BYTES      = 11;   // longest text: "-2147483648"
  localparam int RESET_CYCLES    = 9;
  // Worst request is eleven characters plus the conversion; pad it
  localparam int DRAIN_CYCLES    = 32;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int NUM_PHASES      = 4;
  localparam int ITEMS_PER_PHASE = 74;
  localparam int NUM_DIRECTED    = 24;

  typedef logic [itoa_pkg::CHAR_W-1:0] glyph_q_t[$];

  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] code;
    logic                        last;
  } text_char_t;

  // One directed request; typed rows carry their text, the rest go to the predictor
  typedef struct packed {
    logic [itoa_pkg::TYPE_W-1:0]            kind;
    logic [itoa_pkg::WORD_W-1:0]            word;
    logic                                   typed;
    logic [TEXT_BYTES*itoa_pkg::CHAR_W-1:0] txt;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // zero in every numeric kind
    '{itoa_pkg::KIND_SDEC, 32'h0000_0000,   1'b1, "0"},
    '{itoa_pkg::KIND_UDEC, 32'h0000_0000,   1'b1, "0"},
    '{itoa_pkg::KIND_HEX,  32'h0000_0000,   1'b1, "0"},
    // signed extremes, the most negative value is the longest text
    '{itoa_pkg::KIND_SDEC, 32'h8000_0000,   1'b1, "-2147483648"},
    '{itoa_pkg::KIND_SDEC, 32'h7FFF_FFFF,   1'b1, "2147483647"},
    '{itoa_pkg::KIND_SDEC, 32'hFFFF_FFFF,   1'b1, "-1"},
    '{itoa_pkg::KIND_UDEC, 32'hFFFF_FFFF,   1'b1, "4294967295"},
    '{itoa_pkg::KIND_UDEC, 32'h8000_0000,   1'b1, "2147483648"},
    '{itoa_pkg::KIND_HEX,  32'hFFFF_FFFF,   1'b1, "ffffffff"},
    '{itoa_pkg::KIND_HEX,  32'h8000_0000,   1'b1, "80000000"},
    // character takes the low byte only, byte zero included
    '{itoa_pkg::KIND_CHAR, 32'hFFFF_FF41,   1'b1, "A"},
    '{itoa_pkg::KIND_CHAR, 32'h0000_0000,   1'b0, ""},
    '{itoa_pkg::KIND_CHAR, 32'h0000_00FF,   1'b0, ""},
    '{itoa_pkg::KIND_PCT,  32'h0000_0000,   1'b1, "%"},
    '{itoa_pkg::KIND_PCT,  32'hFFFF_FFFF,   1'b1, "%"},
    // unused kinds write nothing
    '{KIND_UNUSED_LO,      32'h0000_0000,   1'b1, ""},
    '{KIND_UNUSED_MID,     32'hFFFF_FFFF,   1'b1, ""},
    '{KIND_UNUSED_HI,      32'h1234_5678,   1'b1, ""},
    // digit-count boundaries, checked by the predictor
    '{itoa_pkg::KIND_SDEC, 32'h8000_0001,   1'b0, ""},
    '{itoa_pkg::KIND_SDEC, 32'h0000_0001,   1'b0, ""},
    '{itoa_pkg::KIND_UDEC, 32'd999999999,   1'b0, ""},
    '{itoa_pkg::KIND_UDEC, 32'd1000000000,  1'b0, ""},
    '{itoa_pkg::KIND_HEX,  32'h0000_0009,   1'b0, ""},
    '{itoa_pkg::KIND_HEX,  32'h0123_ABCD,   1'b0, ""}
  };

  logic clk = 1'b0;
  logic rst;

  itoa_req_if  req_ch();
  itoa_char_if text_ch();

  integer_to_ascii_formatter u_dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_ch),
    .text (text_ch)
  );

  // Characters still owed by the block, oldest first
  text_char_t  expected_text[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  always #1 clk = ~clk;

  // Printf-style text for one request: sign, then digits most significant first
  function automatic glyph_q_t format_request(input logic [itoa_pkg::TYPE_W-1:0] kind,
                                              input logic [itoa_pkg::WORD_W-1:0] word);
    glyph_q_t                    glyphs;
    logic [itoa_pkg::WORD_W-1:0] mag;
    logic [itoa_pkg::WORD_W-1:0] base;
    logic [itoa_pkg::WORD_W-1:0] digit;
    mag  = word;
    base = (kind == itoa_pkg::KIND_HEX) ? 32'd16 : 32'd10;
    case (kind)
      itoa_pkg::KIND_SDEC, itoa_pkg::KIND_UDEC, itoa_pkg::KIND_HEX: begin
        // negate in 32 bits: exact even for the most negative value
        if (kind == itoa_pkg::KIND_SDEC && word[itoa_pkg::WORD_W-1])
          mag = -word;
        do begin
          digit = mag % base;
          glyphs.push_front((digit < 10)
                            ? ("0" + digit[itoa_pkg::CHAR_W-1:0])
                            : ("a" - 8'd10 + digit[itoa_pkg::CHAR_W-1:0]));
          mag = mag / base;
        end while (mag != 0);
        if (kind == itoa_pkg::KIND_SDEC && word[itoa_pkg::WORD_W-1])
          glyphs.push_front(itoa_pkg::CHAR_MINUS);
      end
      itoa_pkg::KIND_CHAR: glyphs.push_back(word[itoa_pkg::CHAR_W-1:0]);
      itoa_pkg::KIND_PCT:  glyphs.push_back(itoa_pkg::CHAR_PERCENT);
      default: ;   // unused kind: drop, nothing written
    endcase
    return glyphs;
  endfunction

  // Present one request, hold it until taken, then queue its characters
  task automatic send_request(input logic [itoa_pkg::TYPE_W-1:0] kind,
                              input logic [itoa_pkg::WORD_W-1:0] word,
                              input glyph_q_t glyphs);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.arg_word <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    foreach (glyphs[i])
      expected_text.push_back('{glyphs[i], 1'(i == glyphs.size() - 1)});
  endtask

  // Hold off the sender until all text is out, then let a dropped request finish too
  task automatic settle_text();
    req_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sink side: stall at random per the current phase
  always @(posedge clk) begin
    text_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check every accepted character against the oldest expectation
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (expected_text.size() == 0) begin
        $error("char_code: expected none, actual %h (last %b)",
               text_ch.char_code, text_ch.last);
        mismatches++;
      end else begin
        want = expected_text.pop_front();
        if (text_ch.char_code !== want.code) begin
          $error("char_code: expected %h, actual %h", want.code, text_ch.char_code);
          mismatches++;
        end
        if (text_ch.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, text_ch.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (text_ch.valid && text_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_integer_to_ascii_formatter NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    glyph_q_t                    glyphs;
    stim_row_t                   row;
    logic [itoa_pkg::TYPE_W-1:0] kind;
    logic [itoa_pkg::WORD_W-1:0] word;
    logic [itoa_pkg::WORD_W-1:0] power;
    int unsigned                 pick;

    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = itoa_pkg::KIND_SDEC;
    req_ch.arg_word = '0;
    text_ch.ready   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table, no idling on either side
    foreach (DIRECTED_ROWS[r]) begin
      row = DIRECTED_ROWS[r];
      if (row.typed) begin
        // unpack the literal, skipping its zero padding on the left
        glyphs = {};
        for (int b = TEXT_BYTES - 1; b >= 0; b--)
          if (glyphs.size() != 0 || row.txt[b*itoa_pkg::CHAR_W +: itoa_pkg::CHAR_W] != '0)
            glyphs.push_back(row.txt[b*itoa_pkg::CHAR_W +: itoa_pkg::CHAR_W]);
      end else begin
        glyphs = format_request(row.kind, row.word);
      end
      send_request(row.kind, row.word, glyphs);
    end
    settle_text();

    // Random requests, one idle/stall mix per phase, drained between phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 52; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin send_idle_pct = 27; sink_stall_pct = 27; end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 25)      kind = itoa_pkg::KIND_SDEC;
        else if (pick < 45) kind = itoa_pkg::KIND_UDEC;
        else if (pick < 65) kind = itoa_pkg::KIND_HEX;
        else if (pick < 80) kind = itoa_pkg::KIND_CHAR;
        else if (pick < 90) kind = itoa_pkg::KIND_PCT;
        else begin
          case ($urandom_range(2))
            0:       kind = KIND_UNUSED_LO;
            1:       kind = KIND_UNUSED_MID;
            default: kind = KIND_UNUSED_HI;
          endcase
        end
        // mix small values, decimal and binary boundaries, and full-range words
        case ($urandom_range(4))
          0: word = itoa_pkg::WORD_W'($urandom_range(20));
          1: begin
            power = 1;
            repeat ($urandom_range(9)) power = power * 10;
            word = power + itoa_pkg::WORD_W'($urandom_range(2)) - 1;
          end
          2: word = (32'd1 << $urandom_range(31)) - itoa_pkg::WORD_W'($urandom_range(1));
          default: word = $urandom();
        endcase
        send_request(kind, word, format_request(kind, word));
      end
      settle_text();
    end

    if (mismatches == 0)
      $display("tb_integer_to_ascii_formatter OK");
    else
      $display("tb_integer_to_ascii_formatter NOT OK");
    $finish;
  end

endmodule
